// ===== sv/lmt_pkg.sv =====
// Shared constants and types for the LRU miss tracker.
// Used by lmt_cell and the lru_miss_tracker top level; depends on nothing.
package lmt_pkg;

   // number of slot cells in the recency chain
   localparam int WAYS      = 16;
   // width of a page identifier
   localparam int PAGE_BITS = 16;
   // width of the capacity register
   localparam int CAP_W     = 5;
   // width of the miss counter
   localparam int CNT_W     = 32;
   // reset value of the capacity register
   localparam int CAP_RESET = 16;

   // slot index and fill count widths follow from the number of slots
   localparam int IDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_W = $clog2(WAYS + 1);

   typedef logic [PAGE_BITS-1:0] page_type;
   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [FILL_W-1:0]    fill_type;
   typedef logic [CAP_W-1:0]     cap_type;
   typedef logic [CNT_W-1:0]     cnt_type;

   // broadcast from the control logic to every cell
   typedef struct packed {
      logic     step;      // a word is accepted this cycle
      logic     hit;       // the word matched a resident page
      logic     evict;     // the oldest page leaves the chain
      idx_type  wr_idx;    // slot that takes the new page
      fill_type fill;      // resident pages before this word
      page_type new_page;  // page carried by the accepted word
   } cell_ctrl_type;

endpackage

// ===== sv/lmt_cell.sv =====
// One slot cell of the recency chain: holds one page, compares it with the
// incoming page and shifts in its younger neighbor. Depends on lmt_pkg.
module lmt_cell (
   input  logic                   clock,
   input  lmt_pkg::cell_ctrl_type ctrl,
   input  lmt_pkg::idx_type       cell_idx,
   input  logic                   prefix_in,
   input  lmt_pkg::page_type      upper_page,
   output logic                   prefix_out,
   output logic                   match,
   output lmt_pkg::page_type      page_out
);
   import lmt_pkg::*;

   page_type page_ff;
   page_type page_in;
   logic     occupied;
   logic     shift;
   logic     load;

   // compare against the incoming page only while this slot is resident
   assign occupied   = {{(FILL_W - IDX_W){1'b0}}, cell_idx} < ctrl.fill;
   assign match      = occupied && (page_ff == ctrl.new_page);
   assign prefix_out = prefix_in | match;

   // on a hit, close the gap above the hit slot; on an eviction, shift all
   assign shift = ctrl.hit ? prefix_out : ctrl.evict;
   assign load  = (cell_idx == ctrl.wr_idx);

   // pick the next page: the new word wins, then the neighbor, else hold
   always_comb begin
      page_in = page_ff;
      if (ctrl.step) begin
         if (load) begin
            page_in = ctrl.new_page;
         end else if (shift) begin
            page_in = upper_page;
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
   end

   assign page_out = page_ff;

endmodule

// ===== sv/lru_miss_tracker.sv =====
// Top level of the LRU miss tracker: capacity register, fill and miss counters,
// result register and the row of lmt_cell slots. Depends on lmt_pkg, lmt_cell.
//
// Usage:
//   req_valid/req_ready carry one page identifier per word (req_page_id).
//   rsp_valid/rsp_ready return one word per request: rsp_hit, rsp_evicted_valid,
//   rsp_evicted_page (zero when nothing was evicted) and rsp_miss_count, the
//   saturating reload total after this access.
//   csr_valid/csr_ready write the capacity (csr_wdata, 0 acts as 1, values
//   above the slot count act as the slot count). csr_ready is always high;
//   write it only while no request is in flight.
// Result: registered; a request accepted in one cycle shows its result word in the next.
// Throughput: one request per cycle while rsp_ready drains the result. All
//   slots compare the page in parallel and shift their neighbor in the same
//   cycle, so the single update of the slot row per cycle sets the rate.
// Stall: the result sits in a one-word output register; req_ready is high
//   while that register is empty or being drained in the same cycle.
// Reset: no pages resident, miss count zero, capacity 16, no result pending.
//   No clearing pass; the block accepts requests right after reset.
module lru_miss_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lmt_pkg::page_type     req_page_id,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic                  rsp_evicted_valid,
   output lmt_pkg::page_type     rsp_evicted_page,
   output lmt_pkg::cnt_type      rsp_miss_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  lmt_pkg::cap_type      csr_wdata
);
   import lmt_pkg::*;

   cap_type       cap_ff;
   cap_type       cap_in;
   fill_type      fill_ff;
   fill_type      fill_in;
   cnt_type       miss_ff;
   cnt_type       miss_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic          rsp_hit_ff;
   logic          rsp_ev_valid_ff;
   page_type      rsp_ev_page_ff;
   page_type      rsp_ev_page_in;
   cnt_type       rsp_miss_ff;

   fill_type      eff_cap;
   logic          accept;
   logic          hit;
   logic          full;
   logic          evict;
   cell_ctrl_type ctrl;

   logic     [WAYS:0]     prefix;
   logic     [WAYS-1:0]   match_vec;
   page_type [WAYS:0]     pages;

   // clamp the capacity into the range the slot row supports
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = fill_type'(1);
      end else if (32'(cap_ff) > WAYS) begin
         eff_cap = fill_type'(WAYS);
      end else begin
         eff_cap = fill_type'(cap_ff);
      end
   end

   // handshake: take a word while the result register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // decode hit or eviction from the chain
   assign hit   = prefix[WAYS];
   assign full  = (fill_ff >= eff_cap) && (fill_ff != '0);
   assign evict = !hit && full;

   // broadcast to all cells
   always_comb begin
      ctrl.step     = accept;
      ctrl.hit      = hit;
      ctrl.evict    = evict;
      ctrl.fill     = fill_ff;
      ctrl.new_page = req_page_id;
      if (hit || evict) begin
         ctrl.wr_idx = idx_type'(fill_ff - fill_type'(1));
      end else begin
         ctrl.wr_idx = idx_type'(fill_ff);
      end
   end

   // row of slot cells, oldest page in slot 0
   assign prefix[0]   = 1'b0;
   assign pages[WAYS] = '0;

   for (genvar k = 0; k < WAYS; k++) begin : g_cell
      lmt_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_idx   (idx_type'(k)),
         .prefix_in  (prefix[k]),
         .upper_page (pages[k+1]),
         .prefix_out (prefix[k+1]),
         .match      (match_vec[k]),
         .page_out   (pages[k])
      );
   end

   // next values of the counters and the capacity register
   always_comb begin
      cap_in  = cap_ff;
      fill_in = fill_ff;
      miss_in = miss_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_wdata;
      end
      if (accept && !hit) begin
         if (miss_ff != '1) begin
            miss_in = miss_ff + cnt_type'(1);
         end
         if (!evict) begin
            fill_in = fill_ff + fill_type'(1);
         end
      end
   end

   // result word
   assign rsp_valid_in   = accept || (rsp_valid_ff && !rsp_ready);
   assign rsp_ev_page_in = evict ? pages[0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= cap_type'(CAP_RESET);
         fill_ff      <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         fill_ff      <= fill_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result payload on accept, hold it otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_hit_ff      <= hit;
         rsp_ev_valid_ff <= evict;
         rsp_ev_page_ff  <= rsp_ev_page_in;
         rsp_miss_ff     <= miss_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_miss_count    = rsp_miss_ff;

   // resident pages are distinct, so at most one slot matches
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one slot matched the page");

   // the fill count never passes the slot count
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= WAYS)
      else $error("fill count beyond slot count");

   // a hit never reports an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_ev_valid_ff))
      else $error("eviction reported on a hit");

   // a miss that evicts nothing grows residency by one
   a_fill_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && !hit && !evict) |=> (fill_ff == $past(fill_ff) + fill_type'(1)))
      else $error("fill count did not grow on a miss");

   // a hit leaves the miss count unchanged
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (accept && hit) |=> (miss_ff == $past(miss_ff)))
      else $error("miss count changed on a hit");

endmodule

// ===== dv/tb_lru_miss_tracker.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lru_miss_tracker: a shadow recency list predicts each result word.
// Depends on lmt_pkg, lmt_cell and the lru_miss_tracker RTL; needs no other files.
module tb_lru_miss_tracker;
   import lmt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RAND_PHASES = 8;
   localparam int PHASE_WORDS = 225;
   localparam int MAX_PRINTS  = 20;

   // expected content of one result word
   typedef struct packed {
      logic     hit;
      logic     ev_valid;
      page_type ev_page;
      cnt_type  misses;
   } access_word_type;

   // shadow of the tracker: recency order, fill, reload count and capacity
   class lru_shadow;
      page_type        order [WAYS];   // entry 0 is least recently used
      int              resident;
      cnt_type         reloads;
      cap_type         cap;
      access_word_type pending_q[$];
      int              errors, printed;
      int              accesses, hits, evictions, cap_writes;

      function new();
         resident   = 0;
         reloads    = '0;
         cap        = cap_type'(CAP_RESET);
         errors     = 0;
         printed    = 0;
         accesses   = 0;
         hits       = 0;
         evictions  = 0;
         cap_writes = 0;
      endfunction

      function void set_capacity(cap_type v);
         cap = v;
         cap_writes++;
      endfunction

      // zero acts as one slot, anything above the slot count as the slot count
      function int slots_in_use();
         if (cap == 0) return 1;
         if (cap > WAYS) return WAYS;
         return int'(cap);
      endfunction

      // predict the word for an accepted page and update the recency order
      function void note_access(page_type pg);
         access_word_type w;
         int pos;
         w   = '0;
         pos = -1;
         for (int k = 0; k < resident; k++)
            if (pos < 0 && order[k] == pg) pos = k;
         if (pos >= 0) begin
            // hit: move the page to the most recently used end
            w.hit = 1'b1;
            for (int k = pos; k < resident - 1; k++) order[k] = order[k + 1];
            order[resident - 1] = pg;
            hits++;
         end else begin
            // miss: count, drop the oldest page once full, append the new one
            if (reloads != '1) reloads++;
            if (resident >= slots_in_use() && resident > 0) begin
               w.ev_valid = 1'b1;
               w.ev_page  = order[0];
               for (int k = 0; k < resident - 1; k++) order[k] = order[k + 1];
               resident--;
               evictions++;
            end
            order[resident] = pg;
            resident++;
         end
         w.misses = reloads;
         accesses++;
         pending_q = {pending_q, w};
      endfunction

      task report(string msg);
         errors++;
         if (printed < MAX_PRINTS) begin
            $display("MISMATCH at %0t ns: %0s", $time, msg);
            printed++;
         end
      endtask

      // compare one result word against the oldest prediction
      task check_word(access_word_type got);
         access_word_type want;
         if (pending_q.size() == 0) begin
            report("result word with no access pending");
            return;
         end
         want = pending_q.pop_front();
         if (got.hit !== want.hit)
            report($sformatf("hit got %0b want %0b", got.hit, want.hit));
         if (got.ev_valid !== want.ev_valid)
            report($sformatf("evicted_valid got %0b want %0b", got.ev_valid, want.ev_valid));
         if (got.ev_page !== want.ev_page)
            report($sformatf("evicted_page got %h want %h", got.ev_page, want.ev_page));
         if (got.misses !== want.misses)
            report($sformatf("miss_count got %0d want %0d", got.misses, want.misses));
      endtask
   endclass

   logic     clock;
   logic     reset       = 1'b1;
   logic     req_valid   = 1'b0;
   logic     req_ready;
   page_type req_page_id = '0;
   logic     rsp_valid;
   logic     rsp_ready   = 1'b0;
   logic     rsp_hit;
   logic     rsp_evicted_valid;
   page_type rsp_evicted_page;
   cnt_type  rsp_miss_count;
   logic     csr_valid   = 1'b0;
   logic     csr_ready;
   cap_type  csr_wdata   = '0;

   int gap_pct   = 0;   // chance in a hundred that the sender idles a cycle
   int stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
   int cycles    = 0;

   lru_shadow shadow = new();

   lru_miss_tracker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_id       (req_page_id),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_miss_count    (rsp_miss_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // stall the result channel at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watch all three channels: check results, predict accepted words, track capacity
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            shadow.check_word({rsp_hit, rsp_evicted_valid, rsp_evicted_page, rsp_miss_count});
         if (req_valid && req_ready)
            shadow.note_access(req_page_id);
         if (csr_valid && csr_ready)
            shadow.set_capacity(csr_wdata);
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   // present one page, idling first at random; return at the edge that takes it
   task automatic send_page(input page_type pg);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_page_id <= pg;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold until every result word is back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending_q.size() != 0) @(posedge clock);
   endtask

   // write the capacity while the tracker is idle
   task automatic write_capacity(input cap_type v);
      drain_results();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int       base_gap, base_stall, pool_n, slots;
      bit       quiet;
      cap_type  cap_v;
      page_type pool [32];

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extreme pages, hits and misses at the reset capacity
      send_page(16'h0000);
      send_page(16'hFFFF);
      send_page(16'h0000);
      send_page(16'hFFFF);

      // capacity zero acts as one slot while two pages stay resident
      write_capacity(5'd0);
      send_page(16'h1234);
      send_page(16'hFFFF);
      send_page(16'h1234);
      send_page(16'hAAAA);

      // capacity above the slot count: fill every slot, then evict
      write_capacity(5'd31);
      for (int k = 0; k < 15; k++)
         send_page(k == 0 ? 16'h5555 : page_type'(1) << k);

      // random phases over capacities and idling modes
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case (ph)
            0: cap_v = 5'd16;
            1: cap_v = 5'd1;
            2: cap_v = 5'd31;
            3: cap_v = 5'd0;
            4: cap_v = cap_type'($urandom_range(2, 15));
            5: cap_v = 5'd8;
            6: cap_v = cap_type'($urandom_range(0, 31));
            default: cap_v = 5'd3;
         endcase
         write_capacity(cap_v);

         case (ph % 4)
            0: begin base_gap = 0;  base_stall = 0;  end
            1: begin base_gap = 74; base_stall = 0;  end
            2: begin base_gap = 0;  base_stall = 74; end
            default: begin base_gap = 8; base_stall = 8; end
         endcase

         // working set a little larger than the cache so hits and misses mix
         slots  = (cap_v == 0) ? 1 : ((cap_v > WAYS) ? WAYS : int'(cap_v));
         pool_n = slots + $urandom_range(1, 8);
         for (int k = 0; k < pool_n; k++) pool[k] = page_type'($urandom);

         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 40 == 0) quiet = ($urandom_range(3) == 0);
            gap_pct   = quiet ? 0 : base_gap;
            stall_pct = quiet ? 0 : base_stall;
            if ($urandom_range(9) < 7)
               send_page(pool[$urandom_range(pool_n - 1)]);
            else
               send_page(page_type'($urandom));
         end
      end

      // drain and let the result register settle
      gap_pct   = 0;
      stall_pct = 0;
      drain_results();
      repeat (4) @(posedge clock);

      $display("summary: %0d accesses, %0d hits, %0d evictions, %0d capacity writes",
               shadow.accesses, shadow.hits, shadow.evictions, shadow.cap_writes);
      $display("summary: %0d mismatches in %0d cycles", shadow.errors, cycles);
      if (shadow.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/lmt_pkg.sv
sv/lmt_cell.sv
sv/lru_miss_tracker.sv
dv/tb_lru_miss_tracker.sv
